@@ rtl/core/nnps_pkg.sv @@
package nnps_pkg;

  // list geometry
  localparam int LIST_DEPTH = 512;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // fixed field widths
  localparam int VAL_W = 32;
  localparam int POS_W = 9;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // input item
  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] data_value;
    logic                    direction;
  } req_t;

  // result item
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             neighbor_found;
    logic             overflow;
  } rsp_t;

  // scan unit status toward the controller
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] position;
    logic             found;
  } scan_status_t;

endpackage

@@ rtl/core/nearest_neighbor_position_search_top.sv @@
// channel | signals                        | item
// req     | req_valid, req_ready, req_data | clear, append or query request
// rsp     | rsp_valid, rsp_ready, rsp_data | position, neighbor flag, overflow
//
// clear and append are handled at once in ST_IDLE; an append result is registered at once.
// a query on a non-empty list turns the cell ring once, with one entry at the
// head per cycle; the scan unit then hands over its done flag and ST_FIN
// registers the result once the output register is free.
// reset (rst, synchronous) empties the list and clears the overflow flag.
// a result waiting on rsp_ready holds the block; a new item is taken once the
// output register is free or being emptied.
module nearest_neighbor_position_search_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  nnps_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output nnps_pkg::rsp_t rsp_data
);
  import nnps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic               req_go;
  logic               out_free;
  logic               full;
  logic               wr_go;
  logic               scan_start;
  logic               shift;
  scan_status_t       status;
  logic [LIST_DEPTH-1:0]   cell_load;
  logic signed [VAL_W-1:0] cell_value [LIST_DEPTH];

  // handshake
  assign out_free   = !rsp_valid || rsp_ready;
  assign req_ready  = (state == ST_IDLE) && out_free;
  assign req_go     = req_valid && req_ready;
  assign full       = count >= CNT_W'(LIST_DEPTH);
  assign wr_go      = req_go && (req_data.req_type == REQ_APPEND) && !full;
  assign scan_start = req_go && (req_data.req_type == REQ_QUERY) && (count != '0);

  // ring of cells, cell 0 is the head seen by the scan unit
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    localparam int Nxt = (g + 1) % LIST_DEPTH;
    assign cell_load[g] = wr_go && (count[IDX_W-1:0] == IDX_W'(g));
    nnps_cell u_cell (
      .clk        (clk),
      .load       (cell_load[g]),
      .shift      (shift),
      .wr_data    (req_data.data_value),
      .next_value (cell_value[Nxt]),
      .value      (cell_value[g])
    );
  end

  nnps_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .query_value (req_data.data_value),
    .ascending   (req_data.direction),
    .count       (count),
    .head_value  (cell_value[0]),
    .shift       (shift),
    .status      (status)
  );

  // request handling, list bookkeeping and sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_go) begin
            unique case (req_data.req_type)
              REQ_CLEAR: begin
                count <= '0;
                ovf   <= 1'b0;
              end
              REQ_APPEND: begin
                rsp_valid <= 1'b1;
                if (full) begin
                  ovf <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                end
              end
              REQ_QUERY: begin
                if (count == '0) begin
                  rsp_valid <= 1'b1;
                end else begin
                  state <= ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (status.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && req_go) begin
      rsp_data.neighbor_found <= 1'b0;
      if (req_data.req_type == REQ_APPEND) begin
        rsp_data.position <= full ? '0 : POS_W'(count);
        rsp_data.overflow <= full | ovf;
      end else begin
        rsp_data.position <= '0;
        rsp_data.overflow <= ovf;
      end
    end else if ((state == ST_FIN) && out_free) begin
      rsp_data.position       <= POS_W'(status.position);
      rsp_data.neighbor_found <= status.found;
      rsp_data.overflow       <= ovf;
    end
  end

endmodule

@@ rtl/core/nnps_cell.sv @@
module nnps_cell (
  input  logic                             clk,
  input  logic                             load,
  input  logic                             shift,
  input  logic signed [nnps_pkg::VAL_W-1:0] wr_data,
  input  logic signed [nnps_pkg::VAL_W-1:0] next_value,
  output logic signed [nnps_pkg::VAL_W-1:0] value
);
  import nnps_pkg::*;

  // one list entry: written on append, rotated toward the head during a scan
  always_ff @(posedge clk) begin
    if (load) begin
      value <= wr_data;
    end else if (shift) begin
      value <= next_value;
    end
  end

endmodule

@@ rtl/core/nnps_scan.sv @@
module nnps_scan (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [nnps_pkg::VAL_W-1:0] query_value,
  input  logic                              ascending,
  input  logic [nnps_pkg::CNT_W-1:0]        count,
  input  logic signed [nnps_pkg::VAL_W-1:0] head_value,
  output logic                              shift,
  output nnps_pkg::scan_status_t            status
);
  import nnps_pkg::*;

  logic                    running;
  logic                    done;
  logic [IDX_W-1:0]        idx;
  logic signed [VAL_W-1:0] qv;
  logic                    asc;
  logic                    found;
  logic signed [VAL_W-1:0] nbr_val;
  logic [IDX_W-1:0]        nbr_idx;
  logic signed [VAL_W-1:0] ext_val;
  logic [IDX_W-1:0]        ext_idx;

  logic in_range;
  logic cand;
  logic better;
  logic ext_better;
  logic last;

  // compares of the entry now at the head of the ring
  always_comb begin
    in_range   = CNT_W'(idx) < count;
    cand       = asc ? (head_value > qv) : (head_value < qv);
    better     = asc ? (head_value < nbr_val) : (head_value > nbr_val);
    ext_better = asc ? (head_value < ext_val) : (head_value > ext_val);
    last       = idx == IDX_W'(LIST_DEPTH - 1);
  end

  // control: one full turn of the ring per query
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && last) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // running best neighbor and fallback extreme, first occurrence wins
  always_ff @(posedge clk) begin
    if (start) begin
      idx   <= '0;
      qv    <= query_value;
      asc   <= ascending;
      found <= 1'b0;
    end else if (running) begin
      idx <= idx + 1'b1;
      if (in_range) begin
        if (cand && (!found || better)) begin
          found   <= 1'b1;
          nbr_val <= head_value;
          nbr_idx <= idx;
        end
        if ((idx == '0) || ext_better) begin
          ext_val <= head_value;
          ext_idx <= idx;
        end
      end
    end
  end

  assign shift           = running;
  assign status.done     = done;
  assign status.found    = found;
  assign status.position = found ? nbr_idx : ext_idx;

endmodule

@@ rtl/core/nnps_checker.sv @@
module nnps_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input nnps_pkg::req_t req_data,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input nnps_pkg::rsp_t rsp_data
);
  import nnps_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result present after reset");

  // a clear item gives no result
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_data.req_type == REQ_CLEAR) |=> !rsp_valid)
    else $error("clear produced a result");

  // an append item gives its result in the next cycle, never a neighbor
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_data.req_type == REQ_APPEND)
    |=> rsp_valid && !rsp_data.neighbor_found)
    else $error("append result missing or flagged as neighbor");

endmodule

bind nearest_neighbor_position_search_top nnps_checker u_nnps_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import nnps_pkg::*;

  // request code the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  localparam logic DIR_BELOW = 1'b0;
  localparam logic DIR_ABOVE = 1'b1;

  // a query turns the whole ring, and input gaps and result stalls add to it
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int MAX_REPORTS    = 10;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data  = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  // shadow of the list
  logic signed [VAL_W-1:0] list_vals [LIST_DEPTH];
  int unsigned             list_len      = 0;
  bit                      list_overflow = 1'b0;

  rsp_t answers_due[$];
  int   fail_count  = 0;
  int   items_sent  = 0;
  int   quiet_cycles = 0;
  int   hold_left   = 0;
  bit   calm_phase  = 1'b0;

  nearest_neighbor_position_search_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  always #5 clk = ~clk;

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // values biased toward ties, near neighbors and the extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return $signed($urandom_range(0, 16)) - 8;
    if (r < 40) begin
      case ($urandom_range(0, 5))
        0: return VAL_MIN;
        1: return VAL_MIN + 1;
        2: return VAL_MAX;
        3: return VAL_MAX - 1;
        4: return 0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  // update the shadow list and work out the answer, if the request has one
  function automatic bit predict_answer(input req_t r, output rsp_t answer);
    int unsigned             idx;
    int unsigned             best;
    logic signed [VAL_W-1:0] e;
    logic signed [VAL_W-1:0] bv;
    bit                      hit;
    answer = '0;
    best   = 0;
    bv     = '0;
    hit    = 1'b0;
    case (r.req_type)
      REQ_CLEAR: begin
        list_len      = 0;
        list_overflow = 1'b0;
        return 1'b0;
      end
      REQ_APPEND: begin
        if (list_len < LIST_DEPTH) begin
          list_vals[list_len] = r.data_value;
          best = list_len;
          list_len++;
        end else begin
          list_overflow = 1'b1;
        end
      end
      REQ_QUERY: begin
        if (list_len != 0) begin
          // nearest strictly below or above, first occurrence wins
          for (idx = 0; idx < list_len; idx++) begin
            e = list_vals[idx];
            if ((r.direction ? (e > r.data_value) : (e < r.data_value)) &&
                (!hit || (r.direction ? (e < bv) : (e > bv)))) begin
              bv   = e;
              best = idx;
              hit  = 1'b1;
            end
          end
          // no neighbor: first maximum going down, first minimum going up
          if (!hit) begin
            bv = list_vals[0];
            for (idx = 1; idx < list_len; idx++) begin
              e = list_vals[idx];
              if (r.direction ? (e < bv) : (e > bv)) begin
                bv   = e;
                best = idx;
              end
            end
          end
        end
      end
      default: return 1'b0;
    endcase
    answer.position       = best[POS_W-1:0];
    answer.neighbor_found = hit;
    answer.overflow       = list_overflow;
    return 1'b1;
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("tb_top: mismatch at %0t: %s", $realtime, what);
  endtask

  // send one item; returns at the edge where it was taken
  task automatic send_req(input logic [1:0] kind, input logic signed [VAL_W-1:0] val,
                          input logic dir);
    req_t item;
    rsp_t answer;
    int   gap;
    item.req_type   = kind;
    item.data_value = val;
    item.direction  = dir;
    gap = calm_phase ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= item;
    do @(negedge clk); while (!req_ready);
    @(posedge clk);
    if (predict_answer(item, answer)) answers_due.push_back(answer);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  // result side back-pressure
  always @(posedge clk) begin
    if (calm_phase) begin
      rsp_ready <= 1'b1;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if (rsp_ready) begin
      hold_left = pick_gap();
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end
    end else begin
      rsp_ready <= 1'b1;
      hold_left = $urandom_range(0, 8);
    end
  end

  // compare each result taken with the oldest answer due
  always @(negedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (answers_due.size() == 0) begin
        note_failure($sformatf("result with nothing due: pos %0d found %0b ovf %0b",
                               rsp_data.position, rsp_data.neighbor_found,
                               rsp_data.overflow));
      end else begin
        want = answers_due.pop_front();
        if (rsp_data.position !== want.position ||
            rsp_data.neighbor_found !== want.neighbor_found ||
            rsp_data.overflow !== want.overflow) begin
          note_failure($sformatf("pos exp %0d got %0d, found exp %0b got %0b, ovf exp %0b got %0b",
                                 want.position, rsp_data.position,
                                 want.neighbor_found, rsp_data.neighbor_found,
                                 want.overflow, rsp_data.overflow));
        end
      end
    end
  end

  // give up when no item moves on either side for too long
  always @(negedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // queries on an empty list, the ignored code, clear without result
  task automatic test_empty_and_unused();
    send_req(REQ_QUERY, 0, DIR_BELOW);
    send_req(REQ_QUERY, VAL_MAX, DIR_ABOVE);
    send_req(REQ_UNUSED, $urandom, DIR_ABOVE);
    send_req(REQ_APPEND, 7, DIR_BELOW);
    send_req(REQ_CLEAR, $urandom, DIR_ABOVE);
    send_req(REQ_QUERY, VAL_MIN, DIR_BELOW);
  endtask

  // neighbors, fallbacks to the extremes and ties on a short list
  task automatic test_directed_search();
    send_req(REQ_APPEND, VAL_MIN, DIR_ABOVE);
    send_req(REQ_APPEND, 5, DIR_BELOW);
    send_req(REQ_APPEND, VAL_MAX, DIR_BELOW);
    send_req(REQ_APPEND, 5, DIR_ABOVE);
    send_req(REQ_APPEND, -3, DIR_BELOW);
    send_req(REQ_APPEND, VAL_MIN, DIR_BELOW);
    send_req(REQ_APPEND, VAL_MAX, DIR_BELOW);
    send_req(REQ_QUERY, 5, DIR_BELOW);
    send_req(REQ_QUERY, 5, DIR_ABOVE);
    send_req(REQ_QUERY, VAL_MIN, DIR_BELOW);
    send_req(REQ_QUERY, VAL_MAX, DIR_ABOVE);
    send_req(REQ_QUERY, VAL_MAX, DIR_BELOW);
    send_req(REQ_QUERY, VAL_MIN, DIR_ABOVE);
    send_req(REQ_QUERY, -3, DIR_ABOVE);
    send_req(REQ_QUERY, 0, DIR_BELOW);
    send_req(REQ_UNUSED, 5, DIR_ABOVE);
    send_req(REQ_QUERY, 6, DIR_ABOVE);
  endtask

  // fill the list to the brim, overflow it, search it, then clear and search a one-entry list
  task automatic test_fill_overflow();
    send_req(REQ_CLEAR, 0, DIR_BELOW);
    calm_phase = 1'b1;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (i == 96) calm_phase = 1'b0;
      send_req(REQ_APPEND, pick_value(), 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < 3; i++) send_req(REQ_APPEND, pick_value(), 1'($urandom_range(0, 1)));
    send_req(REQ_QUERY, VAL_MIN, DIR_BELOW);
    send_req(REQ_QUERY, VAL_MAX, DIR_ABOVE);
    for (int i = 0; i < 4; i++) begin
      send_req(REQ_QUERY, list_vals[$urandom_range(0, LIST_DEPTH - 1)],
               1'($urandom_range(0, 1)));
    end
    send_req(REQ_QUERY, pick_value(), DIR_BELOW);
    send_req(REQ_QUERY, pick_value(), DIR_ABOVE);
    send_req(REQ_CLEAR, $urandom, DIR_BELOW);
    send_req(REQ_APPEND, pick_value(), DIR_ABOVE);
    send_req(REQ_QUERY, pick_value(), 1'($urandom_range(0, 1)));
  endtask

  // short lists built after a clear and searched, plus some loose requests
  task automatic test_random_mix();
    int                      stop_at;
    int unsigned             n;
    logic signed [VAL_W-1:0] v;
    stop_at = items_sent + 300;
    while (items_sent < stop_at) begin
      calm_phase = (items_sent < stop_at - 260);
      if ($urandom_range(0, 99) < 80) begin
        send_req(REQ_CLEAR, $urandom, 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 20);
        repeat (n) send_req(REQ_APPEND, pick_value(), 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 5);
        repeat (n) begin
          if (list_len != 0 && $urandom_range(0, 1)) begin
            v = list_vals[$urandom_range(0, list_len - 1)] + $signed($urandom_range(0, 2)) - 1;
          end else begin
            v = pick_value();
          end
          send_req(REQ_QUERY, v, 1'($urandom_range(0, 1)));
        end
      end else begin
        send_req(2'($urandom_range(0, 3)), pick_value(), 1'($urandom_range(0, 1)));
      end
    end
    calm_phase = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_unused();
    test_directed_search();
    test_fill_overflow();
    test_random_mix();
    req_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
